>>> design/mlbmt_pkg.sv
// Shared types, constants and lane helpers for the multi-lane bus master transfer core.
package mlbmt_pkg;

  // Lane counts and bus shape
  localparam int unsigned MAX_LANES   = 4;
  localparam int unsigned LaneW       = 4;
  localparam logic [3:0]  CmdLen      = 4'd7;
  localparam logic [3:0]  DataLen     = 4'd8;

  // Port word widths
  localparam int unsigned InDataW     = 24;
  localparam int unsigned OutDataW    = 24;

  // Lane width register codes
  localparam logic [1:0] LANES_ONE    = 2'd0;
  localparam logic [1:0] LANES_TWO    = 2'd1;

  // Transfer modes
  localparam logic [1:0] MODE_READ    = 2'd0;
  localparam logic [1:0] MODE_WRITE   = 2'd1;

  // Status bits
  localparam int unsigned StatBusy    = 0;
  localparam int unsigned StatNak     = 1;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_CMD_RISE  = 4'd1,
    PH_CMD_FALL  = 4'd2,
    PH_STAT_RISE = 4'd3,
    PH_STAT_FALL = 4'd4,
    PH_DATA_RISE = 4'd5,
    PH_DATA_FALL = 4'd6,
    PH_FINAL     = 4'd7
  } phase_e;

  // Transfer engine state
  typedef struct packed {
    phase_e            phase;
    logic [3:0]        bit_count;
    logic [7:0]        shift_out;
    logic [7:0]        shift_in;
    logic [LaneW-1:0]  lane_levels;
    logic              clock_reg;
    logic [1:0]        status_reg;
    logic [1:0]        mode_latch;
    logic              first_chunk;
    logic [7:0]        wbyte_latch;
  } xfer_state_t;

  // One tick of pin inputs
  typedef struct packed {
    logic              start_req;
    logic [1:0]        mode;
    logic [6:0]        command_bits;
    logic [7:0]        write_data;
    logic              miso;
    logic [LaneW-1:0]  lanes_in;
  } tick_in_t;

  // One tick of pin outputs
  typedef struct packed {
    logic              clock_level;
    logic              select_active;
    logic [LaneW-1:0]  lanes_out;
    logic              lanes_driven;
    logic              idle;
    logic              done_res;
    logic [1:0]        status;
    logic [7:0]        read_byte;
  } tick_out_t;

  // Active lane count for a width code, clamped to the lanes that exist
  function automatic logic [2:0] lane_total(input logic [1:0] code);
    logic [2:0] n;
    if (code == LANES_ONE) begin
      n = 3'd1;
    end else if (code == LANES_TWO) begin
      n = 3'd2;
    end else begin
      n = 3'd4;
    end
    if (n > 3'(MAX_LANES)) begin
      n = 3'(MAX_LANES);
    end
    return n;
  endfunction

endpackage

>>> design/mlbmt_tick.sv
// Next-state and pin result logic for one half-clock tick of the transfer.
module mlbmt_tick
  import mlbmt_pkg::*;
(
  input  xfer_state_t cur_i,
  input  tick_in_t    tick_i,
  input  logic [1:0]  lane_code_i,
  output xfer_state_t nxt_o,
  output tick_out_t   res_o
);

  // Drive one chunk of the shift register onto the lanes
  function automatic xfer_state_t drive_chunk(input xfer_state_t s, input logic [2:0] n,
                                              input logic is_cmd);
    logic [3:0] lim;
    logic       b;
    lim = is_cmd ? CmdLen : DataLen;
    for (int k = 0; k < LaneW; k++) begin
      if (3'(k) < n && s.bit_count < lim) begin
        b = is_cmd ? s.shift_out[s.bit_count[2:0]]
                   : s.shift_out[3'd7 - s.bit_count[2:0]];
        s.lane_levels[k] = b;
        s.bit_count = s.bit_count + 4'd1;
      end
    end
    return s;
  endfunction

  // Shift in one chunk of sampled lanes, lowest lane first
  function automatic xfer_state_t sample_chunk(input xfer_state_t s, input logic [2:0] n,
                                               input logic [LaneW-1:0] lanes);
    for (int k = 0; k < LaneW; k++) begin
      if (3'(k) < n && s.bit_count < DataLen) begin
        s.shift_in = {s.shift_in[6:0], lanes[k]};
        s.bit_count = s.bit_count + 4'd1;
      end
    end
    return s;
  endfunction

  logic [2:0]  n_lanes;
  logic        done;
  xfer_state_t nxt;

  assign n_lanes = lane_total(lane_code_i);

  // Advance the transfer by one half period
  always_comb begin
    nxt  = cur_i;
    done = 1'b0;
    unique case (cur_i.phase)
      PH_IDLE: begin
        nxt.clock_reg = 1'b0;
        if (tick_i.start_req) begin
          nxt.mode_latch  = tick_i.mode;
          nxt.shift_out   = {1'b0, tick_i.command_bits};
          nxt.wbyte_latch = tick_i.write_data;
          nxt.shift_in    = '0;
          nxt.status_reg  = '0;
          nxt.bit_count   = '0;
          nxt.first_chunk = 1'b0;
          nxt             = drive_chunk(nxt, n_lanes, 1'b1);
          nxt.phase       = PH_CMD_RISE;
        end
      end
      PH_CMD_RISE: begin
        nxt.clock_reg = 1'b1;
        nxt.phase     = PH_CMD_FALL;
      end
      PH_CMD_FALL: begin
        nxt.clock_reg = 1'b0;
        if (cur_i.bit_count < CmdLen) begin
          nxt       = drive_chunk(nxt, n_lanes, 1'b1);
          nxt.phase = PH_CMD_RISE;
        end else begin
          nxt.phase = PH_STAT_RISE;
        end
      end
      PH_STAT_RISE: begin
        nxt.clock_reg = 1'b1;
        if (tick_i.miso) begin
          nxt.status_reg[StatBusy] = 1'b1;
        end
        nxt.phase = PH_STAT_FALL;
      end
      PH_STAT_FALL: begin
        nxt.clock_reg = 1'b0;
        if (cur_i.mode_latch != MODE_READ && cur_i.mode_latch != MODE_WRITE) begin
          done = 1'b1;
        end else if (cur_i.status_reg[StatBusy]) begin
          nxt.phase = PH_FINAL;
        end else begin
          nxt.bit_count   = '0;
          nxt.first_chunk = 1'b1;
          if (cur_i.mode_latch == MODE_WRITE) begin
            nxt.shift_out = cur_i.wbyte_latch;
            nxt           = drive_chunk(nxt, n_lanes, 1'b0);
          end
          nxt.phase = PH_DATA_RISE;
        end
      end
      PH_DATA_RISE: begin
        if (cur_i.mode_latch == MODE_READ) begin
          nxt = sample_chunk(nxt, n_lanes, tick_i.lanes_in);
        end
        nxt.clock_reg = 1'b1;
        nxt.phase     = PH_DATA_FALL;
        // NAK on the first data chunk aborts on the next edge
        if (cur_i.first_chunk) begin
          nxt.first_chunk = 1'b0;
          if (tick_i.miso) begin
            nxt.status_reg[StatNak] = 1'b1;
            nxt.phase               = PH_FINAL;
          end
        end
      end
      PH_DATA_FALL: begin
        nxt.clock_reg = 1'b0;
        if (cur_i.bit_count < DataLen) begin
          if (cur_i.mode_latch == MODE_WRITE) begin
            nxt = drive_chunk(nxt, n_lanes, 1'b0);
          end
          nxt.phase = PH_DATA_RISE;
        end else begin
          nxt.phase = PH_FINAL;
        end
      end
      PH_FINAL: begin
        nxt.clock_reg = ~cur_i.clock_reg;
        done          = 1'b1;
      end
      default: begin
        nxt.clock_reg = 1'b0;
        nxt.phase     = PH_IDLE;
      end
    endcase
    if (done) begin
      nxt.phase = PH_IDLE;
    end
  end

  assign nxt_o = nxt;

  // Form the pin levels after this tick
  always_comb begin
    res_o.clock_level   = nxt.clock_reg;
    res_o.select_active = (nxt.phase != PH_IDLE);
    res_o.lanes_out     = nxt.lane_levels;
    res_o.lanes_driven  = !(nxt.mode_latch == MODE_READ && nxt.phase >= PH_STAT_RISE &&
                            nxt.phase <= PH_FINAL);
    res_o.idle          = (nxt.phase == PH_IDLE);
    res_o.done_res      = done;
    res_o.status        = done ? nxt.status_reg : 2'b00;
    res_o.read_byte     = (done && nxt.mode_latch == MODE_READ) ? nxt.shift_in : 8'h00;
  end

endmodule

>>> design/multi_lane_bus_master_transfer_core.sv
// Top level of the multi-lane bus master: stream ports, state and result registers.
// Each input word is one half period of the bus clock; its result word is registered and
// appears in the cycle after acceptance, from the output register.
// One word is accepted every cycle; the only stall is a full output register that the
// downstream side does not take in the same cycle.
// Reset (rst_ni low, asynchronous) returns the engine to idle with the bus clock low, all
// lanes low, status cleared, the lane width register at one lane and the output empty.
module multi_lane_bus_master_transfer_core
  import mlbmt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Lane width register
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i,
  // Tick input: [0] start_req, [2:1] mode, [9:3] command_bits, [17:10] write_data,
  // [18] miso, [22:19] lanes_in, [23] zero
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  // Tick result: [0] clock_level, [1] select_active, [5:2] lanes_out, [6] lanes_driven,
  // [7] idle, [9:8] status, [17:10] read_byte, [23:18] zero
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  // done_res: transfer finished on this tick
  output logic                m_axis_tlast
);

  logic [1:0]          lane_code_q;
  xfer_state_t         state_q, state_d;
  tick_in_t            tick_in;
  tick_out_t           tick_res;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic                out_last_q;
  logic                accept;

  // Unpack the input word
  assign tick_in.start_req    = s_axis_tdata[0];
  assign tick_in.mode         = s_axis_tdata[2:1];
  assign tick_in.command_bits = s_axis_tdata[9:3];
  assign tick_in.write_data   = s_axis_tdata[17:10];
  assign tick_in.miso         = s_axis_tdata[18];
  assign tick_in.lanes_in     = s_axis_tdata[22:19];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  mlbmt_tick u_tick (
    .cur_i       (state_q),
    .tick_i      (tick_in),
    .lane_code_i (lane_code_q),
    .nxt_o       (state_d),
    .res_o       (tick_res)
  );

  // Lane width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_code_q <= LANES_ONE;
    end else if (cfg_we_i) begin
      lane_code_q <= cfg_wdata_i;
    end
  end

  // Advance the engine on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, default: '0};
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {6'b0, tick_res.read_byte, tick_res.status, tick_res.idle,
                     tick_res.lanes_driven, tick_res.lanes_out, tick_res.select_active,
                     tick_res.clock_level};
      out_last_q <= tick_res.done_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // A finished transfer leaves the engine idle with select released
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[7] && !m_axis_tdata[1]))
    else $error("done word without idle");

  // Status and read byte are only reported with done
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[17:8] == 10'd0))
    else $error("status or read byte outside done");

  // Bit counter never runs past one byte
  a_bit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bit_count <= DataLen)
    else $error("bit counter overrun");

  // A stalled result blocks new words
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !accept)
    else $error("word accepted over a stalled result");

  // The engine only moves on an accepted word
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(state_q))
    else $error("state changed without a word");

endmodule
